>>> sv/glf_pkg.sv
// shared constants and types of the grid local minimum finder
`default_nettype none
package glf_pkg;

  localparam int MAX_COLUMNS  = 128;
  localparam int MAX_ROWS     = 128;
  localparam int HEIGHT_BITS  = 4;
  localparam int COL_W        = $clog2(MAX_COLUMNS);
  localparam int ROW_W        = $clog2(MAX_ROWS);
  localparam int CFG_W        = 8;
  localparam int RISK_W       = 5;
  localparam int RISK_TOTAL_W = 19;
  localparam int LOW_TOTAL_W  = 15;
  localparam int QUEUE_DEPTH  = 8;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int NUM_JUDGE    = 3;
  localparam int NUM_W        = 2;

  localparam logic [CFG_W-1:0] GRID_SIZE_RESET = CFG_W'(100);

  // configuration register indexes
  localparam logic [0:0] REG_GRID_COLUMNS = 1'b0;
  localparam logic [0:0] REG_GRID_ROWS    = 1'b1;

  // one cell between the scan stage and the judge stage
  typedef struct packed {
    logic [ROW_W-1:0]       row;
    logic [COL_W-1:0]       col;
    logic [HEIGHT_BITS-1:0] height;
    logic                   judge_above;  // cell above is judged now
    logic                   judge_prev;   // last row: cell to the left is judged now
    logic                   judge_end;    // last cell of the grid
    logic                   has_up2;
    logic                   has_left;
    logic                   has_left2;
    logic                   has_right;
    logic                   fwd_older;
    logic [NUM_W-1:0]       count;
  } stage_t;

  typedef struct packed {
    logic [ROW_W-1:0]        cell_row;
    logic [COL_W-1:0]        cell_column;
    logic                    is_low;
    logic [RISK_W-1:0]       risk;
    logic [RISK_TOTAL_W-1:0] risk_total;
    logic [LOW_TOTAL_W-1:0]  low_total;
    logic                    run_last;
    logic                    grid_done;
  } result_t;

endpackage
`default_nettype wire

>>> sv/glf_ram.sv
// generic single write port memory with registered read
`default_nettype none
module glf_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 128,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/glf_ctrl.sv
// configuration registers, raster counters, input acceptance and scan stage
`default_nettype none
module glf_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [0:0]                        cfg_index,
  input  wire logic [glf_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                              height_valid,
  output logic                                   height_stall,
  input  wire logic [glf_pkg::HEIGHT_BITS-1:0]   height,
  input  wire logic [glf_pkg::QPTR_W:0]          queue_count,
  output logic                                   accept,
  output logic [glf_pkg::COL_W-1:0]              col,
  output logic [glf_pkg::COL_W-1:0]              col_right,
  output logic                                   stage_valid,
  output glf_pkg::stage_t                        stage
);

  logic [glf_pkg::CFG_W-1:0] grid_columns;
  logic [glf_pkg::CFG_W-1:0] grid_rows;
  logic [glf_pkg::CFG_W-1:0] cols_eff;
  logic [glf_pkg::CFG_W-1:0] rows_eff;
  logic [glf_pkg::COL_W-1:0] cols_last;
  logic [glf_pkg::ROW_W-1:0] rows_last;
  logic [glf_pkg::COL_W-1:0] column_position;
  logic [glf_pkg::ROW_W-1:0] row_position;
  logic                      last_col;
  logic                      last_row;
  logic [glf_pkg::NUM_W-1:0] n_here;
  logic [glf_pkg::QPTR_W+1:0] demand;
  glf_pkg::stage_t           stage_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (grid_columns == '0) begin
      cols_eff = glf_pkg::CFG_W'(1);
    end else if (grid_columns > glf_pkg::CFG_W'(glf_pkg::MAX_COLUMNS)) begin
      cols_eff = glf_pkg::CFG_W'(glf_pkg::MAX_COLUMNS);
    end else begin
      cols_eff = grid_columns;
    end
    if (grid_rows == '0) begin
      rows_eff = glf_pkg::CFG_W'(1);
    end else if (grid_rows > glf_pkg::CFG_W'(glf_pkg::MAX_ROWS)) begin
      rows_eff = glf_pkg::CFG_W'(glf_pkg::MAX_ROWS);
    end else begin
      rows_eff = grid_rows;
    end
    cols_last = glf_pkg::COL_W'(cols_eff - glf_pkg::CFG_W'(1));
    rows_last = glf_pkg::ROW_W'(rows_eff - glf_pkg::CFG_W'(1));

    if (column_position > glf_pkg::COL_W'(glf_pkg::MAX_COLUMNS - 1)) begin
      col = glf_pkg::COL_W'(glf_pkg::MAX_COLUMNS - 1);
    end else begin
      col = column_position;
    end
    // only used when a right neighbour exists, so wrap is harmless
    col_right = col + glf_pkg::COL_W'(1);
    last_col  = col >= cols_last;
    last_row  = row_position >= rows_last;

    stage_next.row         = row_position;
    stage_next.col         = col;
    stage_next.height      = height;
    stage_next.judge_above = row_position != '0;
    stage_next.judge_prev  = last_row && (col != '0);
    stage_next.judge_end   = last_row && last_col;
    stage_next.has_up2     = row_position >= glf_pkg::ROW_W'(2);
    stage_next.has_left    = col != '0;
    stage_next.has_left2   = col >= glf_pkg::COL_W'(2);
    stage_next.has_right   = !last_col;
    // older row write of the judge stage lands on the edge of this read
    stage_next.fwd_older   = stage_valid && (stage.col == col);
    n_here = glf_pkg::NUM_W'(stage_next.judge_above) + glf_pkg::NUM_W'(stage_next.judge_prev)
           + glf_pkg::NUM_W'(stage_next.judge_end);
    stage_next.count       = n_here;

    // reserve queue space for everything still in flight
    demand = (glf_pkg::QPTR_W+2)'(queue_count)
           + (glf_pkg::QPTR_W+2)'(stage_valid ? stage.count : '0)
           + (glf_pkg::QPTR_W+2)'(n_here);
    height_stall = demand > (glf_pkg::QPTR_W+2)'(glf_pkg::QUEUE_DEPTH);
    accept = height_valid && !height_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns    <= glf_pkg::GRID_SIZE_RESET;
      grid_rows       <= glf_pkg::GRID_SIZE_RESET;
      column_position <= '0;
      row_position    <= '0;
      stage_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          glf_pkg::REG_GRID_COLUMNS: grid_columns <= cfg_data;
          glf_pkg::REG_GRID_ROWS:    grid_rows    <= cfg_data;
        endcase
      end
      stage_valid <= accept;
      if (accept) begin
        if (last_col) begin
          column_position <= '0;
          if (last_row) begin
            row_position <= '0;
          end else begin
            row_position <= row_position + glf_pkg::ROW_W'(1);
          end
        end else begin
          column_position <= col + glf_pkg::COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= stage_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/glf_judge.sv
// judge stage: neighbour compares, running totals and result ordering
`default_nettype none
module glf_judge (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                stage_valid,
  input  wire glf_pkg::stage_t                     stage,
  input  wire logic [glf_pkg::HEIGHT_BITS-1:0]     mid,
  input  wire logic [glf_pkg::HEIGHT_BITS-1:0]     right,
  input  wire logic [glf_pkg::HEIGHT_BITS-1:0]     older_up,
  output logic                                     push,
  output logic [glf_pkg::NUM_W-1:0]                push_count,
  output glf_pkg::result_t [glf_pkg::NUM_JUDGE-1:0] results
);

  localparam int SUM_W = glf_pkg::RISK_TOTAL_W + 1;
  localparam int CNT_W = glf_pkg::LOW_TOTAL_W + 1;

  logic [glf_pkg::HEIGHT_BITS-1:0]  left_height;
  logic [glf_pkg::HEIGHT_BITS-1:0]  prev_h;
  logic [glf_pkg::HEIGHT_BITS-1:0]  prev2_h;
  logic [glf_pkg::RISK_TOTAL_W-1:0] risk_sum;
  logic [glf_pkg::LOW_TOTAL_W-1:0]  low_count;

  logic [glf_pkg::HEIGHT_BITS-1:0]  up1;
  logic                             low1, low2, low3;
  logic [glf_pkg::RISK_W-1:0]       risk1, risk2, risk3;
  logic                             hit1, hit2, hit3;
  logic [SUM_W-1:0]                 sum1, sum2, sum3;
  logic [CNT_W-1:0]                 cnt1, cnt2, cnt3;
  glf_pkg::result_t                 j1, j2, j3;

  function automatic logic below_all(
    input logic [glf_pkg::HEIGHT_BITS-1:0] center,
    input logic up_en, input logic [glf_pkg::HEIGHT_BITS-1:0] up,
    input logic left_en, input logic [glf_pkg::HEIGHT_BITS-1:0] left,
    input logic right_en, input logic [glf_pkg::HEIGHT_BITS-1:0] rgt,
    input logic down_en, input logic [glf_pkg::HEIGHT_BITS-1:0] down
  );
    below_all = !(up_en && up <= center) && !(left_en && left <= center)
             && !(right_en && rgt <= center) && !(down_en && down <= center);
  endfunction

  function automatic logic [glf_pkg::RISK_TOTAL_W-1:0] sat_sum(input logic [SUM_W-1:0] v);
    if (v > SUM_W'({glf_pkg::RISK_TOTAL_W{1'b1}})) begin
      sat_sum = {glf_pkg::RISK_TOTAL_W{1'b1}};
    end else begin
      sat_sum = glf_pkg::RISK_TOTAL_W'(v);
    end
  endfunction

  function automatic logic [glf_pkg::LOW_TOTAL_W-1:0] sat_cnt(input logic [CNT_W-1:0] v);
    if (v > CNT_W'({glf_pkg::LOW_TOTAL_W{1'b1}})) begin
      sat_cnt = {glf_pkg::LOW_TOTAL_W{1'b1}};
    end else begin
      sat_cnt = glf_pkg::LOW_TOTAL_W'(v);
    end
  endfunction

  always_comb begin
    up1 = stage.fwd_older ? left_height : older_up;

    // cell above, cell to the left in the last row, final cell of the grid
    low1 = below_all(mid, stage.has_up2, up1, stage.has_left, left_height,
                     stage.has_right, right, 1'b1, stage.height);
    low2 = below_all(prev_h, stage.judge_above, left_height, stage.has_left2, prev2_h,
                     1'b1, stage.height, 1'b0, '0);
    low3 = below_all(stage.height, stage.judge_above, mid, stage.has_left, prev_h,
                     1'b0, '0, 1'b0, '0);

    hit1 = stage.judge_above && low1;
    hit2 = stage.judge_prev && low2;
    hit3 = stage.judge_end && low3;
    risk1 = hit1 ? glf_pkg::RISK_W'(mid) + glf_pkg::RISK_W'(1) : '0;
    risk2 = hit2 ? glf_pkg::RISK_W'(prev_h) + glf_pkg::RISK_W'(1) : '0;
    risk3 = hit3 ? glf_pkg::RISK_W'(stage.height) + glf_pkg::RISK_W'(1) : '0;

    // saturation is monotone, so prefix sums saturate once at the end
    sum1 = SUM_W'(risk_sum) + SUM_W'(risk1);
    sum2 = sum1 + SUM_W'(risk2);
    sum3 = sum2 + SUM_W'(risk3);
    cnt1 = CNT_W'(low_count) + CNT_W'(hit1);
    cnt2 = cnt1 + CNT_W'(hit2);
    cnt3 = cnt2 + CNT_W'(hit3);

    j1.cell_row    = stage.row - glf_pkg::ROW_W'(1);
    j1.cell_column = stage.col;
    j1.is_low      = low1;
    j1.risk        = risk1;
    j1.risk_total  = sat_sum(sum1);
    j1.low_total   = sat_cnt(cnt1);
    j1.run_last    = !stage.judge_prev && !stage.judge_end;
    j1.grid_done   = 1'b0;

    j2.cell_row    = stage.row;
    j2.cell_column = stage.col - glf_pkg::COL_W'(1);
    j2.is_low      = low2;
    j2.risk        = risk2;
    j2.risk_total  = sat_sum(sum2);
    j2.low_total   = sat_cnt(cnt2);
    j2.run_last    = !stage.judge_end;
    j2.grid_done   = 1'b0;

    j3.cell_row    = stage.row;
    j3.cell_column = stage.col;
    j3.is_low      = low3;
    j3.risk        = risk3;
    j3.risk_total  = sat_sum(sum3);
    j3.low_total   = sat_cnt(cnt3);
    j3.run_last    = 1'b1;
    j3.grid_done   = 1'b1;

    // pack the present judgements to the front
    if (stage.judge_above) begin
      results[0] = j1;
      results[1] = stage.judge_prev ? j2 : j3;
    end else begin
      results[0] = stage.judge_prev ? j2 : j3;
      results[1] = j3;
    end
    results[2] = j3;

    push       = stage_valid;
    push_count = stage.count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_height <= '0;
      prev_h      <= '0;
      prev2_h     <= '0;
      risk_sum    <= '0;
      low_count   <= '0;
    end else if (stage_valid) begin
      left_height <= mid;
      prev_h      <= stage.height;
      prev2_h     <= prev_h;
      if (stage.judge_end) begin
        risk_sum  <= '0;
        low_count <= '0;
      end else begin
        risk_sum  <= sat_sum(sum3);
        low_count <= sat_cnt(cnt3);
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/glf_queue.sv
// result queue: takes up to three results a cycle, hands out one while head_stall is low
`default_nettype none
module glf_queue (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 push,
  input  wire logic [glf_pkg::NUM_W-1:0]            push_count,
  input  wire glf_pkg::result_t [glf_pkg::NUM_JUDGE-1:0] results,
  output logic [glf_pkg::QPTR_W:0]                  count,
  output logic                                      head_valid,
  input  wire logic                                 head_stall,
  output glf_pkg::result_t                          head
);

  glf_pkg::result_t            entries [glf_pkg::QUEUE_DEPTH];
  logic [glf_pkg::QPTR_W-1:0]  wr_ptr;
  logic [glf_pkg::QPTR_W-1:0]  rd_ptr;
  logic [glf_pkg::QPTR_W-1:0]  waddr [glf_pkg::NUM_JUDGE];
  logic                        pop;
  logic [glf_pkg::QPTR_W:0]    added;

  always_comb begin
    for (int i = 0; i < glf_pkg::NUM_JUDGE; i++) begin
      waddr[i] = wr_ptr + glf_pkg::QPTR_W'(i);
    end
    head_valid = count != '0;
    head       = entries[rd_ptr];
    pop        = head_valid && !head_stall;
    added      = push ? (glf_pkg::QPTR_W+1)'(push_count) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + glf_pkg::QPTR_W'(added);
      if (pop) begin
        rd_ptr <= rd_ptr + glf_pkg::QPTR_W'(1);
      end
      count <= count + added - (glf_pkg::QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < glf_pkg::NUM_JUDGE; i++) begin
      if (push && (glf_pkg::NUM_W'(i) < push_count)) begin
        entries[waddr[i]] <= results[i];
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/grid_local_minimum_finder.sv
// the first result a cell causes passes the scan stage register and the result queue before
// it transfers; throughput: one cell per clock unless height_stall; line buffer reads are
// registered and feed the judge stage; most cells of the last row give two results and its
// final cell three, so there the single result port sets the pace at one result per clock
// unless result_stall; the result queue holds eight entries; reset clears counters, totals,
// queue and sets both grid sizes to 100; line buffers are not cleared, no pass after reset
`default_nettype none
module grid_local_minimum_finder (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [0:0]                          cfg_index,
  input  wire logic [glf_pkg::CFG_W-1:0]           cfg_data,
  input  wire logic                                height_valid,
  output logic                                     height_stall,
  input  wire logic [glf_pkg::HEIGHT_BITS-1:0]     height,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output logic [glf_pkg::ROW_W-1:0]                cell_row,
  output logic [glf_pkg::COL_W-1:0]                cell_column,
  output logic                                     is_low,
  output logic [glf_pkg::RISK_W-1:0]               risk,
  output logic [glf_pkg::RISK_TOTAL_W-1:0]         risk_total,
  output logic [glf_pkg::LOW_TOTAL_W-1:0]          low_total,
  output logic                                     run_last,
  output logic                                     grid_done
);

  logic                                      accept;
  logic [glf_pkg::COL_W-1:0]                 col;
  logic [glf_pkg::COL_W-1:0]                 col_right;
  logic                                      stage_valid;
  glf_pkg::stage_t                           stage;
  logic [glf_pkg::HEIGHT_BITS-1:0]           mid;
  logic [glf_pkg::HEIGHT_BITS-1:0]           right;
  logic [glf_pkg::HEIGHT_BITS-1:0]           older_up;
  logic                                      push;
  logic [glf_pkg::NUM_W-1:0]                 push_count;
  glf_pkg::result_t [glf_pkg::NUM_JUDGE-1:0] results;
  logic [glf_pkg::QPTR_W:0]                  queue_count;
  glf_pkg::result_t                          head;

  glf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .height_valid (height_valid),
    .height_stall (height_stall),
    .height       (height),
    .queue_count  (queue_count),
    .accept       (accept),
    .col          (col),
    .col_right    (col_right),
    .stage_valid  (stage_valid),
    .stage        (stage)
  );

  // newer row, one copy per read port; written with the incoming cell
  glf_ram #(.WIDTH(glf_pkg::HEIGHT_BITS), .DEPTH(glf_pkg::MAX_COLUMNS)) u_newer_mid (
    .clk   (clk),
    .we    (accept),
    .waddr (col),
    .wdata (height),
    .raddr (col),
    .rdata (mid)
  );

  glf_ram #(.WIDTH(glf_pkg::HEIGHT_BITS), .DEPTH(glf_pkg::MAX_COLUMNS)) u_newer_right (
    .clk   (clk),
    .we    (accept),
    .waddr (col),
    .wdata (height),
    .raddr (col_right),
    .rdata (right)
  );

  // older row takes the cell moved out of the newer row
  glf_ram #(.WIDTH(glf_pkg::HEIGHT_BITS), .DEPTH(glf_pkg::MAX_COLUMNS)) u_older (
    .clk   (clk),
    .we    (stage_valid),
    .waddr (stage.col),
    .wdata (mid),
    .raddr (col),
    .rdata (older_up)
  );

  glf_judge u_judge (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage       (stage),
    .mid         (mid),
    .right       (right),
    .older_up    (older_up),
    .push        (push),
    .push_count  (push_count),
    .results     (results)
  );

  glf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_count (push_count),
    .results    (results),
    .count      (queue_count),
    .head_valid (result_valid),
    .head_stall (result_stall),
    .head       (head)
  );

  assign cell_row    = head.cell_row;
  assign cell_column = head.cell_column;
  assign is_low      = head.is_low;
  assign risk        = head.risk;
  assign risk_total  = head.risk_total;
  assign low_total   = head.low_total;
  assign run_last    = head.run_last;
  assign grid_done   = head.grid_done;

endmodule
`default_nettype wire

>>> bench/testbench.sv
// testbench for the grid local minimum finder: predicted judgements checked against the block
`default_nettype none
module testbench;

  localparam int RISK_SUM_LIMIT  = (1 << glf_pkg::RISK_TOTAL_W) - 1;
  localparam int LOW_COUNT_LIMIT = (1 << glf_pkg::LOW_TOTAL_W) - 1;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_LIMIT     = 5000;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [0:0]                       cfg_index = glf_pkg::REG_GRID_COLUMNS;
  logic [glf_pkg::CFG_W-1:0]        cfg_data = '0;
  logic                             height_valid = 1'b0;
  logic                             height_stall;
  logic [glf_pkg::HEIGHT_BITS-1:0]  height = '0;
  logic                             result_valid;
  logic                             result_stall = 1'b0;
  logic [glf_pkg::ROW_W-1:0]        cell_row;
  logic [glf_pkg::COL_W-1:0]        cell_column;
  logic                             is_low;
  logic [glf_pkg::RISK_W-1:0]       risk;
  logic [glf_pkg::RISK_TOTAL_W-1:0] risk_total;
  logic [glf_pkg::LOW_TOTAL_W-1:0]  low_total;
  logic                             run_last;
  logic                             grid_done;

  grid_local_minimum_finder dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .height_valid(height_valid), .height_stall(height_stall), .height(height),
    .result_valid(result_valid), .result_stall(result_stall),
    .cell_row(cell_row), .cell_column(cell_column), .is_low(is_low), .risk(risk),
    .risk_total(risk_total), .low_total(low_total), .run_last(run_last), .grid_done(grid_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the block state
  logic [glf_pkg::CFG_W-1:0]     columns_reg = glf_pkg::GRID_SIZE_RESET;
  logic [glf_pkg::CFG_W-1:0]     rows_reg = glf_pkg::GRID_SIZE_RESET;
  bit [glf_pkg::HEIGHT_BITS-1:0] older_line [glf_pkg::MAX_COLUMNS];
  bit [glf_pkg::HEIGHT_BITS-1:0] newer_line [glf_pkg::MAX_COLUMNS];
  int                            left_h = 0;
  int                            row_pos = 0;
  int                            col_pos = 0;
  int                            risk_acc = 0;
  int                            low_acc = 0;

  glf_pkg::result_t pending_judgements [$];
  int               failures = 0;
  int               cells_sent = 0;

  // pacing of both sides
  int gap_max = 0;
  int stall_pct = 0;
  int burst_left = 0;
  int stall_left = 0;
  bit stall_now = 1'b0;

  function automatic int clamp_size(input logic [glf_pkg::CFG_W-1:0] v, input int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : int'(v);
  endfunction

  function automatic glf_pkg::result_t judge_cell(input int r, input int c, input int center,
      input bit has_up, input int up, input bit has_left, input int lft,
      input bit has_right, input int rgt, input bit has_down, input int down, input bit done);
    glf_pkg::result_t res;
    bit               low;
    int               gain;
    low = 1'b1;
    if (has_up && up <= center) low = 1'b0;
    if (has_left && lft <= center) low = 1'b0;
    if (has_right && rgt <= center) low = 1'b0;
    if (has_down && down <= center) low = 1'b0;
    gain = low ? center + 1 : 0;
    if (low) begin
      risk_acc = (risk_acc + gain > RISK_SUM_LIMIT) ? RISK_SUM_LIMIT : risk_acc + gain;
      if (low_acc < LOW_COUNT_LIMIT) low_acc++;
    end
    res.cell_row    = glf_pkg::ROW_W'(r);
    res.cell_column = glf_pkg::COL_W'(c);
    res.is_low      = low;
    res.risk        = glf_pkg::RISK_W'(gain);
    res.risk_total  = glf_pkg::RISK_TOTAL_W'(risk_acc);
    res.low_total   = glf_pkg::LOW_TOTAL_W'(low_acc);
    res.run_last    = 1'b0;
    res.grid_done   = done;
    return res;
  endfunction

  // judgements caused by one accepted cell, in the order the block emits them
  function automatic void predict_cell(input int h);
    int               cols, rows, r, c, mid;
    bit               last_col, last_row;
    glf_pkg::result_t found [$];
    cols = clamp_size(columns_reg, glf_pkg::MAX_COLUMNS);
    rows = clamp_size(rows_reg, glf_pkg::MAX_ROWS);
    r = row_pos;
    c = col_pos;
    last_col = c >= cols - 1;
    last_row = r >= rows - 1;
    mid = newer_line[c];
    // right neighbour index wraps only when it does not exist
    if (r > 0)
      found.push_back(judge_cell(r - 1, c, mid, r >= 2, older_line[c], c > 0, left_h,
                                 !last_col, newer_line[(c + 1) % glf_pkg::MAX_COLUMNS],
                                 1'b1, h, 1'b0));
    if (last_row && c > 0)
      found.push_back(judge_cell(r, c - 1, newer_line[c - 1], r > 0, older_line[c - 1],
                                 c >= 2, (c >= 2) ? newer_line[c - 2] : 0, 1'b1, h,
                                 1'b0, 0, 1'b0));
    if (last_row && last_col)
      found.push_back(judge_cell(r, c, h, r > 0, mid, c > 0, (c > 0) ? newer_line[c - 1] : 0,
                                 1'b0, 0, 1'b0, 0, 1'b1));
    if (found.size() > 0) found[found.size() - 1].run_last = 1'b1;
    foreach (found[i]) pending_judgements.push_back(found[i]);
    left_h = mid;
    older_line[c] = glf_pkg::HEIGHT_BITS'(mid);
    newer_line[c] = glf_pkg::HEIGHT_BITS'(h);
    if (last_col) begin
      col_pos = 0;
      if (last_row) begin
        row_pos = 0;
        risk_acc = 0;
        low_acc = 0;
      end else begin
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    glf_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_judgements.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual row %0d column %0d",
                 $time, cell_row, cell_column);
        failures++;
      end else begin
        want = pending_judgements.pop_front();
        check_field("cell_row", want.cell_row, cell_row);
        check_field("cell_column", want.cell_column, cell_column);
        check_field("is_low", want.is_low, is_low);
        check_field("risk", want.risk, risk);
        check_field("risk_total", want.risk_total, risk_total);
        check_field("low_total", want.low_total, low_total);
        check_field("run_last", want.run_last, run_last);
        check_field("grid_done", want.grid_done, grid_done);
      end
    end
  end

  // receiver stalls in runs of random length
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_now = $urandom_range(0, 99) < stall_pct;
      stall_left = $urandom_range(1, 6);
    end
    stall_left--;
    result_stall <= stall_now;
  end

  task automatic send_cell(input int h);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        height_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    height_valid <= 1'b1;
    height <= glf_pkg::HEIGHT_BITS'(h);
    do @(posedge clk); while (height_stall);
    predict_cell(h);
    cells_sent++;
    @(negedge clk);
  endtask

  // let every expected result arrive, then let the pipeline empty
  task automatic wait_drained();
    int waited;
    waited = 0;
    height_valid <= 1'b0;
    burst_left = 0;
    while (pending_judgements.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (pending_judgements.size() != 0) begin
      $display("%0t: %0d results expected, actual none", $time, pending_judgements.size());
      failures++;
      pending_judgements.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_sizes(input int cols, input int rows);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= glf_pkg::REG_GRID_COLUMNS;
    cfg_data <= glf_pkg::CFG_W'(cols);
    do @(posedge clk); while (!cfg_ready);
    columns_reg = glf_pkg::CFG_W'(cols);
    @(negedge clk);
    cfg_index <= glf_pkg::REG_GRID_ROWS;
    cfg_data <= glf_pkg::CFG_W'(rows);
    do @(posedge clk); while (!cfg_ready);
    rows_reg = glf_pkg::CFG_W'(rows);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic finish_grid();
    do send_cell($urandom_range(0, 15)); while (row_pos != 0 || col_pos != 0);
  endtask

  task automatic test_small_patterns();
    int pattern [9] = '{0, 5, 5, 5, 3, 5, 15, 5, 4};
    gap_max = 0;
    stall_pct = 0;
    write_sizes(3, 3);
    foreach (pattern[i]) send_cell(pattern[i]);
  endtask

  task automatic test_thin_grids();
    int column_cells [4] = '{15, 0, 15, 0};
    int row_cells [4] = '{0, 15, 15, 0};
    gap_max = 3;
    stall_pct = 40;
    // zero in both registers means a single cell
    write_sizes(0, 0);
    send_cell(0);
    send_cell(15);
    write_sizes(1, 4);
    foreach (column_cells[i]) send_cell(column_cells[i]);
    // equal neighbours are not low points
    write_sizes(4, 1);
    foreach (row_cells[i]) send_cell(row_cells[i]);
  endtask

  task automatic test_extreme_sizes();
    // single column: the older row write and read hit the same entry
    gap_max = 2;
    stall_pct = 30;
    write_sizes(1, 5);
    finish_grid();
    // leaves known heights in the first ten entries of both line buffers
    gap_max = 0;
    stall_pct = 0;
    write_sizes(10, 2);
    finish_grid();
    // sizes above the maximum, shrunk before the first row ends
    gap_max = 4;
    stall_pct = 60;
    write_sizes(255, 255);
    repeat (3) send_cell($urandom_range(0, 15));
    write_sizes(4, 2);
    finish_grid();
  endtask

  task automatic test_resize_mid_grid();
    int k;
    repeat (2) begin
      gap_max = $urandom_range(0, 3);
      stall_pct = $urandom_range(0, 70);
      write_sizes(6, 4);
      k = $urandom_range(1, 10);
      repeat (k) send_cell($urandom_range(0, 15));
      write_sizes($urandom_range(1, 10), $urandom_range(1, 4));
      finish_grid();
    end
  endtask

  task automatic test_random_grids();
    int start;
    start = cells_sent;
    while (cells_sent - start < 25) begin
      case ($urandom_range(0, 2))
        0: begin gap_max = 0; stall_pct = 0; end
        1: begin gap_max = 2; stall_pct = 30; end
        default: begin gap_max = 5; stall_pct = 70; end
      endcase
      write_sizes($urandom_range(1, 6), $urandom_range(1, 4));
      finish_grid();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_small_patterns();
    test_thin_grids();
    test_extreme_sizes();
    test_resize_mid_grid();
    test_random_grids();
    wait_drained();
    repeat (10) @(negedge clk);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire
